// File: design/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared widths, status codes and stage record types for the quadratic
// real-roots solver.
// ----------------------------------------------------------------------------
package qrr_pkg;

    localparam int COEF_W   = 16;
    localparam int ROOT_W   = 32;
    localparam int STAT_W   = 2;
    // discriminant B*B - 4*A*C fits in 34 signed bits
    localparam int DISC_W   = 34;
    // radicand D << 30, unsigned, below 2^63
    localparam int RAD_W    = 64;
    localparam int SQRT_W   = 32;
    // numerator -B*2^15 +- s, with s < 2^32
    localparam int NUM_W    = 36;
    localparam int DIV_W    = 16;
    localparam int QUO_W    = 36;
    localparam int SQRT_STEPS = SQRT_W;
    localparam int DIV_STEPS  = NUM_W;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_A_ZERO   = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root_plus;
        logic signed [ROOT_W-1:0] root_minus;
        logic [STAT_W-1:0]        status;
    } result_t;

    // per-item side data that travels alongside the square-root stages
    typedef struct packed {
        status_t                  status;
        logic signed [COEF_W:0]   coef_b;
        logic signed [COEF_W-1:0] coef_a;
    } side_t;

endpackage

// File: design/qrr_if.sv
// ----------------------------------------------------------------------------
// qrr_if
// Valid/ready channel carrying one item of a parameterized payload type.
// ----------------------------------------------------------------------------
interface qrr_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/qrr_sqrt.sv
// ----------------------------------------------------------------------------
// qrr_sqrt
// Pipelined restoring integer square root: one result bit per stage, with a
// remainder-zero flag for the exact-square test.
// ----------------------------------------------------------------------------
module qrr_sqrt
    import qrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    rad,
    input  qrr_pkg::side_t      in_side,
    output logic                out_valid,
    output logic [SQRT_W-1:0]   root,
    output logic                exact,
    output qrr_pkg::side_t      out_side
);
    logic [SQRT_STEPS:0]          v_reg;
    logic [RAD_W-1:0]             rad_reg  [SQRT_STEPS+1];
    logic [SQRT_W+1:0]            rem_reg  [SQRT_STEPS+1];
    logic [SQRT_W-1:0]            q_reg    [SQRT_STEPS+1];
    side_t                        side_reg [SQRT_STEPS+1];

    always_comb
    begin
        v_reg[0]    = in_valid;
        rad_reg[0]  = rad;
        rem_reg[0]  = '0;
        q_reg[0]    = '0;
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_step
        logic [SQRT_W+1:0] trial;
        logic [SQRT_W+1:0] cur;
        logic [SQRT_W+1:0] rem_next;
        logic [SQRT_W-1:0] q_next;

        always_comb
        begin
            // bring down the next two radicand bits
            cur   = {rem_reg[i][SQRT_W-1:0], rad_reg[i][RAD_W-1 -: 2]};
            trial = {q_reg[i], 2'b01};
            if (cur >= trial)
            begin
                rem_next = cur - trial;
                q_next   = {q_reg[i][SQRT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = cur;
                q_next   = {q_reg[i][SQRT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i+1]  <= {rad_reg[i][RAD_W-3:0], 2'b00};
                rem_reg[i+1]  <= rem_next;
                q_reg[i+1]    <= q_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS];
    assign root      = q_reg[SQRT_STEPS];
    assign exact     = (rem_reg[SQRT_STEPS] == '0);
    assign out_side  = side_reg[SQRT_STEPS];
endmodule

// File: design/qrr_div.sv
// ----------------------------------------------------------------------------
// qrr_div
// Pipelined restoring unsigned divider: one quotient bit per stage. A
// numerator magnitude is divided by a 16-bit divisor.
// ----------------------------------------------------------------------------
module qrr_div
    import qrr_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [DIV_W-1:0]   den,
    output logic [QUO_W-1:0]   quo
);
    logic [NUM_W-1:0]  n_reg [DIV_STEPS+1];
    logic [DIV_W-1:0]  d_reg [DIV_STEPS+1];
    logic [DIV_W:0]    r_reg [DIV_STEPS+1];
    logic [QUO_W-1:0]  q_reg [DIV_STEPS+1];

    always_comb
    begin
        n_reg[0] = num;
        d_reg[0] = den;
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [DIV_W+1:0] cur;
        logic [DIV_W:0]   r_next;
        logic             qb;

        always_comb
        begin
            cur = {r_reg[i], n_reg[i][NUM_W-1]};
            qb  = (cur >= {2'b00, d_reg[i]});
            if (qb)
            begin
                r_next = (DIV_W+1)'(cur - {2'b00, d_reg[i]});
            end
            else
            begin
                r_next = cur[DIV_W:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i+1] <= {n_reg[i][NUM_W-2:0], 1'b0};
                d_reg[i+1] <= d_reg[i];
                r_reg[i+1] <= r_next;
                q_reg[i+1] <= {q_reg[i][QUO_W-2:0], qb};
            end
        end
    end

    assign quo = q_reg[DIV_STEPS];
endmodule

// File: design/quadratic_real_roots.sv
// ----------------------------------------------------------------------------
// quadratic_real_roots
// Real roots of a*x^2 + b*x + c = 0, Q8.8 coefficients in, Q16.16 roots out,
// truncated toward zero and saturated.
//
//  channel | dir | payload                              | handshake
//  coef    | in  | coef_a, coef_b, coef_c (s16 each)    | valid/ready
//  roots   | out | root_plus, root_minus (s32), status  | valid/ready
//
// Takes one item per cycle unless the output stalls. Stages in order: products,
// discriminant, classify, bit-per-stage square root, numerators, bit-per-stage
// divide, output register. A stall on the output freezes the whole pipe (ready
// follows roots.ready or an empty output register); no item is dropped or repeated.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module quadratic_real_roots
    import qrr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    qrr_if.sink   coef,
    qrr_if.source roots
);
    localparam int DIV_LAT = DIV_STEPS;

    logic en;
    logic out_v_reg;
    result_t out_reg;

    assign en         = !out_v_reg || roots.ready;
    assign coef.ready = en;

    // ---------------- stage 1: products ----------------
    logic              s1_v_reg;
    logic signed [31:0] bb_reg, ac_reg;
    side_t              s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= coef.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg <= coef.data.coef_b * coef.data.coef_b;
            ac_reg <= coef.data.coef_a * coef.data.coef_c;
            s1_side_reg.coef_a <= coef.data.coef_a;
            s1_side_reg.coef_b <= -((COEF_W+1)'(coef.data.coef_b));
            s1_side_reg.status <= ST_OK;
        end
    end

    // ---------------- stage 2: discriminant ----------------
    logic               s2_v_reg;
    logic signed [DISC_W-1:0] disc_reg;
    side_t              s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_reg    <= DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
            s2_side_reg <= s1_side_reg;
        end
    end

    // ---------------- stage 3: classify, form radicand ----------------
    logic               s3_v_reg;
    logic [RAD_W-1:0]   rad_reg;
    side_t              s3_side_reg;
    logic [RAD_W-1:0]   rad_next;
    side_t              s3_side_next;

    always_comb
    begin
        s3_side_next = s2_side_reg;
        rad_next     = '0;
        if (s2_side_reg.coef_a == '0)
            s3_side_next.status = ST_A_ZERO;
        else if (disc_reg[DISC_W-1])
            s3_side_next.status = ST_NEG_DISC;
        else
            rad_next = RAD_W'(disc_reg[DISC_W-2:0]) << 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s3_side_next;
            rad_reg     <= rad_next;
        end
    end

    // ---------------- square root ----------------
    logic               sq_v;
    logic [SQRT_W-1:0]  sq_root;
    logic               sq_exact;
    side_t              sq_side;

    qrr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s3_v_reg),
        .rad      (rad_reg),
        .in_side  (s3_side_reg),
        .out_valid(sq_v),
        .root     (sq_root),
        .exact    (sq_exact),
        .out_side (sq_side)
    );

    // ---------------- numerators ----------------
    // For positive divisor the plus root truncates from floor (p+s) if it is
    // >= 0, else from ceiling. Sign flip when a < 0 swaps floor/ceiling.
    logic               s4_v_reg;
    logic [NUM_W-1:0]   pmag_reg, mmag_reg;
    logic               pneg_reg, mneg_reg;
    logic [DIV_W-1:0]   den_reg;
    status_t            s4_st_reg;

    logic signed [NUM_W-1:0] p_w, s_w, up_w;
    logic signed [NUM_W-1:0] pf, pc, mf, mc, tpf, tpc, tmf, tmc;
    logic signed [NUM_W-1:0] psel, msel;

    always_comb
    begin
        p_w  = NUM_W'(sq_side.coef_b) <<< 15;
        s_w  = NUM_W'({1'b0, sq_root});
        up_w = sq_exact ? '0 : NUM_W'(1);
        pf = p_w + s_w;
        pc = p_w + s_w + up_w;
        mf = p_w - s_w - up_w;
        mc = p_w - s_w;
        if (sq_side.coef_a[COEF_W-1])
        begin
            tpf = -pc; tpc = -pf;
            tmf = -mc; tmc = -mf;
        end
        else
        begin
            tpf = pf; tpc = pc;
            tmf = mf; tmc = mc;
        end
        // truncation: floor when non-negative, else ceiling magnitude
        psel = tpf[NUM_W-1] ? -tpc : tpf;
        msel = tmf[NUM_W-1] ? -tmc : tmf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= sq_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmag_reg  <= psel;
            mmag_reg  <= msel;
            pneg_reg  <= tpf[NUM_W-1];
            mneg_reg  <= tmf[NUM_W-1];
            den_reg   <= sq_side.coef_a[COEF_W-1] ? DIV_W'(-sq_side.coef_a)
                                                  : DIV_W'(sq_side.coef_a);
            s4_st_reg <= sq_side.status;
        end
    end

    // ---------------- dividers ----------------
    logic [QUO_W-1:0] pq, mq;

    qrr_div u_div_plus (
        .clk(clk), .en(en), .num(pmag_reg),
        .den(den_reg == '0 ? DIV_W'(1) : den_reg), .quo(pq)
    );
    qrr_div u_div_minus (
        .clk(clk), .en(en), .num(mmag_reg),
        .den(den_reg == '0 ? DIV_W'(1) : den_reg), .quo(mq)
    );

    // sign and status travel beside the divider stages
    logic [DIV_LAT:0] dv_reg;
    logic             dpn_reg [DIV_LAT+1];
    logic             dmn_reg [DIV_LAT+1];
    status_t          dst_reg [DIV_LAT+1];

    always_comb
    begin
        dv_reg[0]  = s4_v_reg;
        dpn_reg[0] = pneg_reg;
        dmn_reg[0] = mneg_reg;
        dst_reg[0] = s4_st_reg;
    end

    for (genvar i = 0; i < DIV_LAT; i++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[i+1] <= 1'b0;
            else if (en)
                dv_reg[i+1] <= dv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dpn_reg[i+1] <= dpn_reg[i];
                dmn_reg[i+1] <= dmn_reg[i];
                dst_reg[i+1] <= dst_reg[i];
            end
        end
    end

    // ---------------- sign, clamp, output register ----------------
    logic signed [QUO_W:0] pv, mv;
    logic [ROOT_W-1:0]     pc32, mc32;
    logic                  psat, msat;
    result_t               out_next;
    status_t               st_in;

    function automatic logic [ROOT_W-1:0] clamp(input logic signed [QUO_W:0] v,
                                                output logic sat);
        logic signed [QUO_W:0] hi, lo;
        hi = (QUO_W+1)'(32'sh7FFF_FFFF);
        lo = -((QUO_W+1)'(1) <<< (ROOT_W-1));
        sat = 1'b0;
        if (v > hi)
        begin
            sat = 1'b1;
            return hi[ROOT_W-1:0];
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo[ROOT_W-1:0];
        end
        return v[ROOT_W-1:0];
    endfunction

    always_comb
    begin
        pv    = dpn_reg[DIV_LAT] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
        mv    = dmn_reg[DIV_LAT] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
        pc32  = clamp(pv, psat);
        mc32  = clamp(mv, msat);
        st_in = dst_reg[DIV_LAT];
        out_next.root_plus  = '0;
        out_next.root_minus = '0;
        out_next.status     = st_in;
        if (st_in == ST_OK)
        begin
            out_next.root_plus  = pc32;
            out_next.root_minus = mc32;
            out_next.status     = (psat || msat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_reg[DIV_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign roots.valid = out_v_reg;
    assign roots.data  = out_reg;

    // held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !roots.ready |=> out_v_reg && $stable(out_reg))
        else $error("result changed under stall");
    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && (out_reg.status == ST_NEG_DISC || out_reg.status == ST_A_ZERO)
        |-> out_reg.root_plus == '0 && out_reg.root_minus == '0)
        else $error("roots not zero for invalid status");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> !$isunknown(out_reg))
        else $error("unknown bits in result");
endmodule
